// ===== hw/rtl/sac_pkg.sv =====
package sac_pkg;

  // Default geometry, handed to the top level as parameter defaults
  localparam int unsigned MAX_SET_BITS_DEF = 6;
  localparam int unsigned MAX_WAYS_DEF     = 8;
  localparam int unsigned ADDR_WIDTH_DEF   = 64;
  localparam int unsigned STAMP_WIDTH_DEF  = 32;

  // Fixed field widths
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned ADDR_FLD_W = 64;
  localparam int unsigned OUTCOME_W  = 2;
  localparam int unsigned COUNT_W    = 32;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 6;
  localparam int unsigned SETB_W     = 3;
  localparam int unsigned OFFB_W     = 6;
  localparam int unsigned WAYS_W     = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS        = 2'd2;

  localparam logic [SETB_W-1:0] SET_BITS_RST = 3'd4;
  localparam logic [OFFB_W-1:0] OFFSET_RST   = 6'd4;
  localparam logic [WAYS_W-1:0] WAYS_RST     = 4'd1;

  // Stream layouts (lowest bit first)
  localparam int unsigned IN_KIND_LSB   = 0;
  localparam int unsigned IN_ADDR_LSB   = IN_KIND_LSB + KIND_W;
  localparam int unsigned IN_TDATA_W    = 72;
  localparam int unsigned OUT_OC_LSB    = 0;
  localparam int unsigned OUT_XH_LSB    = OUT_OC_LSB + OUTCOME_W;
  localparam int unsigned OUT_HIT_LSB   = OUT_XH_LSB + 1;
  localparam int unsigned OUT_MISS_LSB  = OUT_HIT_LSB + COUNT_W;
  localparam int unsigned OUT_EVICT_LSB = OUT_MISS_LSB + COUNT_W;
  localparam int unsigned OUT_USED_W    = OUT_EVICT_LSB + COUNT_W;
  localparam int unsigned OUT_TDATA_W   = 104;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_STORE  = 2'd1,
    KIND_MODIFY = 2'd2,
    KIND_IFETCH = 2'd3
  } kind_e;

  typedef enum logic [OUTCOME_W-1:0] {
    OC_HIT     = 2'd0,
    OC_MISS    = 2'd1,
    OC_EVICT   = 2'd2,
    OC_IGNORED = 2'd3
  } outcome_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_LOOKUP = 2'b10
  } state_e;

  // Lookup verdict for one set
  typedef struct packed {
    logic hit;
    logic cold;
  } lookup_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == {COUNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

// ===== hw/rtl/sac_line_ram.sv =====
module sac_line_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned ADDR_W = 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [2**ADDR_W];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/sac_lookup.sv =====
module sac_lookup #(
  parameter int unsigned MAX_WAYS    = sac_pkg::MAX_WAYS_DEF,
  parameter int unsigned ADDR_WIDTH  = sac_pkg::ADDR_WIDTH_DEF,
  parameter int unsigned STAMP_WIDTH = sac_pkg::STAMP_WIDTH_DEF,
  localparam int unsigned WAY_W      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
  localparam int unsigned CNT_W      = $clog2(MAX_WAYS + 1)
) (
  input  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]  tags_i,
  input  logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0] stamps_i,
  input  logic [ADDR_WIDTH-1:0]                tag_i,
  input  logic [sac_pkg::WAYS_W-1:0]           ways_i,
  input  logic [CNT_W-1:0]                     fill_i,
  output sac_pkg::lookup_t                     res_o,
  output logic [WAY_W-1:0]                     way_o
);

  logic [MAX_WAYS-1:0]    match;
  logic                   found;
  logic [WAY_W-1:0]       hit_way;
  logic [WAY_W-1:0]       victim;
  logic [STAMP_WIDTH-1:0] oldest;
  logic                   cold;

  // tag compare on every valid, searched way
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      match[w] = (w < 32'(ways_i)) && (w < 32'(fill_i)) && (tags_i[w] == tag_i);
    end
  end

  // first matching way wins
  always_comb begin
    found   = 1'b0;
    hit_way = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (match[w] && !found) begin
        found   = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  // first way holding the smallest stamp
  always_comb begin
    oldest = stamps_i[0];
    victim = '0;
    for (int w = 1; w < MAX_WAYS; w++) begin
      if ((w < 32'(ways_i)) && (stamps_i[w] < oldest)) begin
        oldest = stamps_i[w];
        victim = WAY_W'(w);
      end
    end
  end

  assign cold       = !found && (32'(fill_i) < 32'(ways_i));
  assign res_o.hit  = found;
  assign res_o.cold = cold;
  assign way_o      = found ? hit_way : (cold ? fill_i[WAY_W-1:0] : victim);

endmodule

// ===== hw/rtl/set_assoc_lru_cache_sim.sv =====
// Channel   Dir  Handshake                     Payload
// cfg       in   cfg_valid_i / cfg_ready_o     cfg_addr_i, cfg_wdata_i
// s_axis    in   s_axis_tvalid / s_axis_tready kind, address
// m_axis    out  m_axis_tvalid / m_axis_tready outcome, extra_hit, three totals
//
// Each request is registered with its set row read from the line RAM,
// then compare, LRU pick and write-back of the whole set row follow.
// A new request is taken while the previous result still waits in the
// output register; lookup holds if that register is full and not drained.
// Reset clears per-set fill counts, stamp and totals at once; no sweep.
module set_assoc_lru_cache_sim #(
  parameter int unsigned MAX_SET_BITS = sac_pkg::MAX_SET_BITS_DEF,
  parameter int unsigned MAX_WAYS     = sac_pkg::MAX_WAYS_DEF,
  parameter int unsigned ADDR_WIDTH   = sac_pkg::ADDR_WIDTH_DEF,
  parameter int unsigned STAMP_WIDTH  = sac_pkg::STAMP_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [sac_pkg::CFG_IDX_W-1:0]      cfg_addr_i,
  input  logic [sac_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // kind[1:0], address[65:2], zero pad
  input  logic [sac_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // outcome[1:0], extra_hit[2], hit_total[34:3], miss_total[66:35],
  // evict_total[98:67], zero pad
  output logic [sac_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  localparam int unsigned SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int unsigned ROWS     = 2**SET_W;
  localparam int unsigned WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned CNT_W    = $clog2(MAX_WAYS + 1);
  localparam int unsigned TAGS_W   = MAX_WAYS * ADDR_WIDTH;
  localparam int unsigned STAMPS_W = MAX_WAYS * STAMP_WIDTH;
  localparam int unsigned ROW_W    = TAGS_W + STAMPS_W;
  localparam int unsigned SH_W     = sac_pkg::OFFB_W + 1;
  localparam int unsigned CW       = sac_pkg::COUNT_W;

  typedef logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]  tag_row_t;
  typedef logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0] stamp_row_t;

  sac_pkg::state_e state_q, state_d;

  logic [sac_pkg::SETB_W-1:0] cfg_set_q;
  logic [sac_pkg::OFFB_W-1:0] cfg_off_q;
  logic [sac_pkg::WAYS_W-1:0] cfg_ways_q;

  logic [sac_pkg::SETB_W-1:0] sbits;
  logic [sac_pkg::WAYS_W-1:0] ways;
  logic [SH_W-1:0]            tag_sh;

  sac_pkg::kind_e        in_kind;
  logic [ADDR_WIDTH-1:0] in_addr;
  logic [ADDR_WIDTH-1:0] set_shift;
  logic [SET_W-1:0]      in_set;
  logic [ADDR_WIDTH-1:0] in_tag;
  logic                  accept;

  sac_pkg::kind_e        kind_q;
  logic [SET_W-1:0]      set_q;
  logic [ADDR_WIDTH-1:0] tag_q;

  logic [CNT_W-1:0] fill_q [ROWS];
  logic [CNT_W-1:0] fill_rd_q;
  logic [CNT_W-1:0] fill;

  logic [ROW_W-1:0]       ram_rdata;
  logic [ROW_W-1:0]       ram_wdata;
  logic                   ram_we;
  tag_row_t               rd_tags, wr_tags;
  stamp_row_t             rd_stamps, wr_stamps;
  sac_pkg::lookup_t       res;
  logic [WAY_W-1:0]       way;

  logic                   done;
  logic                   is_data;
  logic [STAMP_WIDTH-1:0] stamp_q, stamp_d;
  logic [CW-1:0]          hit_q, hit_d, hit_one;
  logic [CW-1:0]          miss_q, miss_d;
  logic [CW-1:0]          evict_q, evict_d;

  sac_pkg::outcome_e outcome_q, outcome_d;
  logic              extra_q;
  logic              out_valid_q;

  // configuration registers, write channel always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_set_q  <= sac_pkg::SET_BITS_RST;
      cfg_off_q  <= sac_pkg::OFFSET_RST;
      cfg_ways_q <= sac_pkg::WAYS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        sac_pkg::CFG_SET_BITS:    cfg_set_q  <= cfg_wdata_i[sac_pkg::SETB_W-1:0];
        sac_pkg::CFG_OFFSET_BITS: cfg_off_q  <= cfg_wdata_i;
        sac_pkg::CFG_WAYS:        cfg_ways_q <= cfg_wdata_i[sac_pkg::WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped geometry
  always_comb begin
    sbits = (32'(cfg_set_q) > MAX_SET_BITS) ? sac_pkg::SETB_W'(MAX_SET_BITS) : cfg_set_q;
    if (cfg_ways_q == '0) begin
      ways = sac_pkg::WAYS_W'(1);
    end else if (32'(cfg_ways_q) > MAX_WAYS) begin
      ways = sac_pkg::WAYS_W'(MAX_WAYS);
    end else begin
      ways = cfg_ways_q;
    end
  end

  // request decode: set and tag from the address
  assign in_kind   = sac_pkg::kind_e'(s_axis_tdata[sac_pkg::IN_KIND_LSB +: sac_pkg::KIND_W]);
  assign in_addr   = s_axis_tdata[sac_pkg::IN_ADDR_LSB +: ADDR_WIDTH];
  assign set_shift = in_addr >> cfg_off_q;
  assign in_set    = set_shift[SET_W-1:0] & ~({SET_W{1'b1}} << sbits);
  assign tag_sh    = SH_W'(cfg_off_q) + SH_W'(sbits);
  assign in_tag    = in_addr >> tag_sh;

  assign s_axis_tready = (state_q == sac_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // request capture, with the fill count of the set read alongside the row
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q    <= in_kind;
      set_q     <= in_set;
      tag_q     <= in_tag;
      fill_rd_q <= fill_q[in_set];
    end
  end

  // set rows: tags low, stamps high
  sac_line_ram #(
    .WIDTH  (ROW_W),
    .ADDR_W (SET_W)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (set_q),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (in_set),
    .rdata_o (ram_rdata)
  );

  assign rd_tags   = tag_row_t'(ram_rdata[TAGS_W-1:0]);
  assign rd_stamps = stamp_row_t'(ram_rdata[ROW_W-1:TAGS_W]);
  assign fill      = fill_rd_q;

  sac_lookup #(
    .MAX_WAYS    (MAX_WAYS),
    .ADDR_WIDTH  (ADDR_WIDTH),
    .STAMP_WIDTH (STAMP_WIDTH)
  ) u_lookup (
    .tags_i   (rd_tags),
    .stamps_i (rd_stamps),
    .tag_i    (tag_q),
    .ways_i   (ways),
    .fill_i   (fill),
    .res_o    (res),
    .way_o    (way)
  );

  // lookup completes once the output register can take the result
  assign done    = (state_q == sac_pkg::ST_LOOKUP) && (!out_valid_q || m_axis_tready);
  assign is_data = (kind_q != sac_pkg::KIND_IFETCH);
  assign stamp_d = stamp_q + 1'b1;

  // write-back: new tag and stamp in the chosen way
  always_comb begin
    wr_tags        = rd_tags;
    wr_stamps      = rd_stamps;
    wr_tags[way]   = tag_q;
    wr_stamps[way] = stamp_d;
  end

  assign ram_we    = done && is_data;
  assign ram_wdata = {wr_stamps, wr_tags};

  // per-set fill counts (valid ways always form a prefix)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) begin
        fill_q[r] <= '0;
      end
    end else if (done && is_data && res.cold) begin
      fill_q[set_q] <= fill + 1'b1;
    end
  end

  // outcome and totals
  always_comb begin
    if (!is_data) begin
      outcome_d = sac_pkg::OC_IGNORED;
    end else if (res.hit) begin
      outcome_d = sac_pkg::OC_HIT;
    end else if (res.cold) begin
      outcome_d = sac_pkg::OC_MISS;
    end else begin
      outcome_d = sac_pkg::OC_EVICT;
    end
    hit_one = (is_data && res.hit) ? sac_pkg::sat_inc(hit_q) : hit_q;
    hit_d   = (kind_q == sac_pkg::KIND_MODIFY) ? sac_pkg::sat_inc(hit_one) : hit_one;
    miss_d  = (is_data && !res.hit) ? sac_pkg::sat_inc(miss_q) : miss_q;
    evict_d = (outcome_d == sac_pkg::OC_EVICT) ? sac_pkg::sat_inc(evict_q) : evict_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stamp_q <= '0;
      hit_q   <= '0;
      miss_q  <= '0;
      evict_q <= '0;
    end else if (done) begin
      if (is_data) begin
        stamp_q <= stamp_d;
      end
      hit_q   <= hit_d;
      miss_q  <= miss_d;
      evict_q <= evict_d;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sac_pkg::ST_IDLE:   if (accept) state_d = sac_pkg::ST_LOOKUP;
      sac_pkg::ST_LOOKUP: if (done)   state_d = sac_pkg::ST_IDLE;
      default:            state_d = sac_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sac_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // output register; totals come straight from the counters,
  // which only move when a new result is loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      outcome_q <= outcome_d;
      extra_q   <= (kind_q == sac_pkg::KIND_MODIFY);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {
    (sac_pkg::OUT_TDATA_W - sac_pkg::OUT_USED_W)'(0),
    evict_q, miss_q, hit_q, extra_q, outcome_q
  };

`ifndef SYNTH
  // a fill count never exceeds the ways of a set
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sac_pkg::ST_LOOKUP) |-> (32'(fill) <= MAX_WAYS))
    else $error("fill count above way count");

  // evictions are a subset of misses
  a_evict_le_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evict_q <= miss_q)
    else $error("eviction total above miss total");

  // the access stamp moves only on a completed data access
  a_stamp_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stamp_q != $past(stamp_q)) |-> $past(done && is_data))
    else $error("stamp advanced without a data access");

  // a request is taken only while the line RAM port is free
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == sac_pkg::ST_LOOKUP) && !s_axis_tready)
    else $error("request overlapped a lookup");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned PHASE_ITEMS  = 190;
  localparam int unsigned NPH          = 9;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned LINES        = (1 << sac_pkg::MAX_SET_BITS_DEF) *
                                         sac_pkg::MAX_WAYS_DEF;

  typedef struct {
    sac_pkg::kind_e kind;
    logic [63:0]    addr;
  } cache_req_t;

  typedef struct {
    sac_pkg::outcome_e outcome;
    logic              extra_hit;
    logic [31:0]       hits;
    logic [31:0]       misses;
    logic [31:0]       evicts;
  } cache_res_t;

  // DUT connections, all inputs known from time zero
  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [sac_pkg::CFG_IDX_W-1:0]   cfg_addr_i = '0;
  logic [sac_pkg::CFG_DATA_W-1:0]  cfg_wdata_i = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [sac_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [sac_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  set_assoc_lru_cache_sim u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  // Shadow cache: geometry, lines, stamp and totals
  logic [sac_pkg::SETB_W-1:0] cfg_set_bits    = sac_pkg::SET_BITS_RST;
  logic [sac_pkg::OFFB_W-1:0] cfg_offset_bits = sac_pkg::OFFSET_RST;
  logic [sac_pkg::WAYS_W-1:0] cfg_ways        = sac_pkg::WAYS_RST;
  bit                line_valid [LINES];
  bit [63:0]         line_tag   [LINES];
  bit [31:0]         line_stamp [LINES];
  bit [31:0]         stamp_now;
  bit [31:0]         hit_tally;
  bit [31:0]         miss_tally;
  bit [31:0]         evict_tally;

  cache_req_t  access_q [$];
  cache_res_t  verdict_q [$];
  cache_req_t  cur_req;
  bit          req_taken;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_req;
  int unsigned hold_left;
  int unsigned err_count;
  int unsigned cycle_count;
  cache_res_t  want;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    err_count++;
    $display("%0t: %s: got %0h, expected %0h", $time, what, got, exp_val);
  endtask

  // Apply one access to the shadow cache and return the verdict
  function automatic cache_res_t predict_access(input sac_pkg::kind_e kind,
                                                input logic [63:0] addr);
    cache_res_t  r;
    int unsigned sb, nw, offb, set_idx, base, w, e, vic, fill;
    bit [63:0]   tg;
    bit [31:0]   oldest;
    bit          hit, cold;
    r.extra_hit = (kind == sac_pkg::KIND_MODIFY);
    if (kind == sac_pkg::KIND_IFETCH) begin
      r.outcome = sac_pkg::OC_IGNORED;
    end else begin
      sb   = (32'(cfg_set_bits) > sac_pkg::MAX_SET_BITS_DEF) ? sac_pkg::MAX_SET_BITS_DEF :
             32'(cfg_set_bits);
      nw   = (cfg_ways == '0) ? 1 :
             ((32'(cfg_ways) > sac_pkg::MAX_WAYS_DEF) ? sac_pkg::MAX_WAYS_DEF : 32'(cfg_ways));
      offb = 32'(cfg_offset_bits);
      set_idx = (offb >= 64) ? 0 : 32'((addr >> offb) & ((64'd1 << sb) - 64'd1));
      tg   = (offb + sb >= 64) ? 64'd0 : (addr >> (offb + sb));
      base = set_idx * sac_pkg::MAX_WAYS_DEF;
      stamp_now++;
      hit = 1'b0;
      cold = 1'b0;
      vic = 0;
      fill = 0;
      oldest = line_stamp[base];
      // scan in way order; the first invalid way ends the search
      for (w = 0; w < nw && !hit && !cold; w++) begin
        e = base + w;
        if (!line_valid[e]) begin
          cold = 1'b1;
          fill = w;
        end else begin
          if (line_stamp[e] < oldest) begin
            oldest = line_stamp[e];
            vic = w;
          end
          if (line_tag[e] == tg) begin
            line_stamp[e] = stamp_now;
            hit = 1'b1;
          end
        end
      end
      if (hit) begin
        r.outcome = sac_pkg::OC_HIT;
        if (hit_tally != '1) hit_tally++;
      end else begin
        r.outcome = cold ? sac_pkg::OC_MISS : sac_pkg::OC_EVICT;
        e = base + (cold ? fill : vic);
        line_valid[e] = 1'b1;
        line_tag[e]   = tg;
        line_stamp[e] = stamp_now;
        if (miss_tally != '1) miss_tally++;
        if (!cold && evict_tally != '1) evict_tally++;
      end
      if (kind == sac_pkg::KIND_MODIFY && hit_tally != '1) hit_tally++;
    end
    r.hits   = hit_tally;
    r.misses = miss_tally;
    r.evicts = evict_tally;
    return r;
  endfunction

  // Register write; only issued while nothing is in flight
  task automatic write_reg(input logic [sac_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sac_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    case (idx)
      sac_pkg::CFG_SET_BITS:    cfg_set_bits    = val[sac_pkg::SETB_W-1:0];
      sac_pkg::CFG_OFFSET_BITS: cfg_offset_bits = val[sac_pkg::OFFB_W-1:0];
      sac_pkg::CFG_WAYS:        cfg_ways        = val[sac_pkg::WAYS_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // look after the driver's update at the falling edge has settled
  task automatic wait_drained();
    do begin
      @(negedge clk_i);
      #1;
    end while (access_q.size() != 0 || s_axis_tvalid || verdict_q.size() != 0);
  endtask

  task automatic push_access(input sac_pkg::kind_e kind, input logic [63:0] addr);
    cache_req_t q;
    q.kind = kind;
    q.addr = addr;
    access_q.push_back(q);
  endtask

  // Random accesses: mostly a small working set, clustered on a few sets
  // so that hits and evictions both show up; n counts every request
  task automatic queue_random(input int unsigned n);
    logic [63:0] pool [48];
    logic [63:0] base [4];
    logic [63:0] keep, lowm;
    int unsigned sb, sh, pool_n, taken, r, i;
    sb = (32'(cfg_set_bits) > sac_pkg::MAX_SET_BITS_DEF) ? sac_pkg::MAX_SET_BITS_DEF :
         32'(cfg_set_bits);
    sh = 32'(cfg_offset_bits) + sb;
    keep = (sh >= 64) ? '1 : ((64'd1 << sh) - 64'd1);
    lowm = (64'd1 << cfg_offset_bits) - 64'd1;
    pool_n = $urandom_range(48, 4);
    for (i = 0; i < 4; i++) base[i] = {$urandom, $urandom};
    for (i = 0; i < pool_n; i++)
      pool[i] = ($urandom_range(1) == 0) ? {$urandom, $urandom} :
                ((base[$urandom_range(3)] & keep) | ({$urandom, $urandom} & ~keep));
    taken = 0;
    while (taken < n) begin
      r = $urandom_range(99);
      if (r < 8) begin
        push_access(sac_pkg::KIND_IFETCH, {$urandom, $urandom});
      end else begin
        push_access(sac_pkg::kind_e'($urandom_range(2)), (r < 16) ? {$urandom, $urandom} :
                    pool[$urandom_range(pool_n - 1)] ^ ({$urandom, $urandom} & lowm));
      end
      taken++;
    end
  endtask

  // Request driver
  always @(negedge clk_i) begin
    if (req_taken || !s_axis_tvalid) begin
      req_taken = 1'b0;
      if (access_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_req = access_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(sac_pkg::IN_TDATA_W - sac_pkg::KIND_W - sac_pkg::ADDR_FLD_W){1'b0}},
                          cur_req.addr, cur_req.kind};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result sink, with an optional long hold-off
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: check results first, then predict newly taken requests
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("result with nothing pending", m_axis_tdata[63:0], '0);
        end else begin
          want = verdict_q.pop_front();
          if (m_axis_tdata[sac_pkg::OUT_OC_LSB +: sac_pkg::OUTCOME_W] !== want.outcome)
            report_mismatch("outcome", m_axis_tdata[sac_pkg::OUT_OC_LSB +: sac_pkg::OUTCOME_W],
                            want.outcome);
          if (m_axis_tdata[sac_pkg::OUT_XH_LSB] !== want.extra_hit)
            report_mismatch("extra_hit", m_axis_tdata[sac_pkg::OUT_XH_LSB], want.extra_hit);
          if (m_axis_tdata[sac_pkg::OUT_HIT_LSB +: sac_pkg::COUNT_W] !== want.hits)
            report_mismatch("hit_total", m_axis_tdata[sac_pkg::OUT_HIT_LSB +: sac_pkg::COUNT_W],
                            want.hits);
          if (m_axis_tdata[sac_pkg::OUT_MISS_LSB +: sac_pkg::COUNT_W] !== want.misses)
            report_mismatch("miss_total",
                            m_axis_tdata[sac_pkg::OUT_MISS_LSB +: sac_pkg::COUNT_W],
                            want.misses);
          if (m_axis_tdata[sac_pkg::OUT_EVICT_LSB +: sac_pkg::COUNT_W] !== want.evicts)
            report_mismatch("evict_total",
                            m_axis_tdata[sac_pkg::OUT_EVICT_LSB +: sac_pkg::COUNT_W],
                            want.evicts);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        verdict_q.push_back(predict_access(cur_req.kind, cur_req.addr));
        req_taken = 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("set_assoc_lru_cache_sim test failed");
      $finish;
    end
  end

  // Geometry per phase: set bits, offset bits, ways
  logic [sac_pkg::CFG_DATA_W-1:0] ph_sb [NPH] =
    '{6'd0, 6'd6, 6'd7, 6'd3, 6'd6, 6'd2, 6'd5, 6'd1, 6'd4};
  logic [sac_pkg::CFG_DATA_W-1:0] ph_ob [NPH] =
    '{6'd0, 6'd6, 6'd5, 6'd63, 6'd58, 6'd10, 6'd32, 6'd1, 6'd4};
  logic [sac_pkg::CFG_DATA_W-1:0] ph_wy [NPH] =
    '{6'd8, 6'd4, 6'd2, 6'd3, 6'd0, 6'd15, 6'd5, 6'd9, 6'd1};

  initial begin : stim
    int unsigned p;
    send_idle_pct = 23;
    recv_idle_pct = 77;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset geometry, one way per set
    push_access(sac_pkg::KIND_LOAD,   64'h0);                  // cold miss
    push_access(sac_pkg::KIND_LOAD,   64'h8);                  // same block, hit
    push_access(sac_pkg::KIND_MODIFY, 64'h0);                  // hit plus extra hit
    push_access(sac_pkg::KIND_STORE,  64'h100);                // same set, new tag
    push_access(sac_pkg::KIND_LOAD,   64'h0);                  // evicts it back
    push_access(sac_pkg::KIND_IFETCH, 64'hFFFF_FFFF_FFFF_FFFF);
    push_access(sac_pkg::KIND_LOAD,   64'hFFFF_FFFF_FFFF_FFFF);
    push_access(sac_pkg::KIND_STORE,  64'hFFFF_FFFF_FFFF_FFF0);
    push_access(sac_pkg::KIND_MODIFY, 64'hAAAA_AAAA_AAAA_AAAA);
    push_access(sac_pkg::KIND_MODIFY, 64'h5555_5555_5555_5555);
    push_access(sac_pkg::KIND_IFETCH, 64'h0);
    push_access(sac_pkg::KIND_LOAD,   64'h10);
    wait_drained();

    // Directed: two ways, LRU victim choice in set 0
    write_reg(sac_pkg::CFG_WAYS, 6'd2);
    push_access(sac_pkg::KIND_LOAD,   64'h100);                // fills way 1
    push_access(sac_pkg::KIND_LOAD,   64'h0);                  // hit, refreshes way 0
    push_access(sac_pkg::KIND_LOAD,   64'h200);                // evicts way 1
    push_access(sac_pkg::KIND_LOAD,   64'h100);                // evicts way 0
    push_access(sac_pkg::KIND_STORE,  64'h200);                // hit
    push_access(sac_pkg::KIND_MODIFY, 64'h300);                // evicts older way

    // Random phases; lines carry over across geometry changes
    for (p = 0; p < NPH; p++) begin
      wait_drained();
      case (p / 3)
        0: begin send_idle_pct = 23; recv_idle_pct = 77; end
        1: begin send_idle_pct = 77; recv_idle_pct = 23; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      write_reg(sac_pkg::CFG_SET_BITS,    ph_sb[p]);
      write_reg(sac_pkg::CFG_OFFSET_BITS, ph_ob[p]);
      write_reg(sac_pkg::CFG_WAYS,        ph_wy[p]);
      queue_random(PHASE_ITEMS / 2);
      // sink stalls long while the source keeps offering
      if (p == 6) hold_req = 1'b1;
      // source pauses until the block is empty
      wait_drained();
      queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
    end

    wait_drained();
    repeat (20) @(negedge clk_i);
    if (verdict_q.size() != 0)
      report_mismatch("results never returned", verdict_q.size(), '0);
    if (err_count == 0) begin
      $display("set_assoc_lru_cache_sim test passed");
    end else begin
      $display("set_assoc_lru_cache_sim test failed");
    end
    $finish;
  end

endmodule

// ===== set_assoc_lru_cache_sim.f =====
hw/rtl/sac_pkg.sv
hw/rtl/sac_line_ram.sv
hw/rtl/sac_lookup.sv
hw/rtl/set_assoc_lru_cache_sim.sv
tb/testbench.sv
